// ----- src/midi_message_framer_unit_assert.svh -----
// Assertion macros used by the framer top level.
`ifndef MIDI_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`define MIDI_MESSAGE_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mmf_pkg.sv -----
package mmf_pkg;

    // SysEx buffer sizing
    localparam int SYSEX_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int SX_CAP      = (SYSEX_DEPTH < MAX_RESULTS) ? SYSEX_DEPTH : MAX_RESULTS;
    localparam int SX_AW       = $clog2(SX_CAP);
    localparam int CNT_W       = $clog2(SX_CAP + 1);

    localparam logic [CNT_W-1:0] SX_CAP_CNT   = CNT_W'(SX_CAP);
    localparam logic [SX_AW-1:0] SX_LAST_ADDR = SX_AW'(SX_CAP - 1);

    // MIDI status codes
    localparam logic [7:0] SX_START    = 8'hF0;
    localparam logic [7:0] SX_END      = 8'hF7;
    localparam logic [7:0] RT_FIRST    = 8'hF8;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_PRESSURE = 8'hD0;
    localparam logic [7:0] ST_SYSTEM   = 8'hF0;
    localparam logic [7:0] ST_MTC      = 8'hF1;
    localparam logic [7:0] ST_SONG_POS = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_SX_RD,
        S_SX_LD
    } t_state;

    // Request from the controller to the SysEx RAM
    typedef struct packed {
        logic             we;
        logic [SX_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [SX_AW-1:0] raddr;
    } t_ram_req;

    // One result byte offered to the output stage
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } t_beat;

    // Message length implied by a status byte
    function automatic logic [1:0] msg_length(input logic [7:0] s);
        logic [1:0] len;
        if (!s[7]) begin
            len = 2'd0;
        end else if (s[7:4] == ST_PROGRAM[7:4] || s[7:4] == ST_PRESSURE[7:4]) begin
            len = 2'd2;
        end else if (s[7:4] == ST_SYSTEM[7:4]) begin
            if (s == SX_START) begin
                len = 2'd0;
            end else if (s == ST_MTC || s == ST_SONG_SEL) begin
                len = 2'd2;
            end else if (s == ST_SONG_POS) begin
                len = 2'd3;
            end else begin
                len = 2'd1;
            end
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

endpackage

// ----- src/midi_message_framer_unit.sv -----
// MIDI message framer: raw MIDI bytes in, complete messages out as runs of
// bytes with tlast on the final byte and tuser marking a truncated SysEx run.
// A channel, system-common or real-time message goes out one byte per cycle
// from the message registers while the sink is ready. A SysEx run (at most
// 32 bytes) is replayed through the buffer RAM's registered read port: each
// byte is read from the RAM and then handed to the output register. Input is
// held off while a message is being sent, and a new byte is taken while the
// last byte of the previous message still waits in the output register.
// Nothing needs clearing after reset. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
`include "midi_message_framer_unit_assert.svh"

module midi_message_framer_unit
    import mmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: output_enabled
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // msg_last
    output logic [0:0] m_axis_tuser    // [0] truncated
);

    t_ram_req   w_ram_req;
    logic [7:0] w_ram_rdata;
    t_beat      w_beat;
    logic       w_out_free;

    assign o_cfg_ready = 1'b1;

    // Parser and emit sequencer
    mmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata),
        .o_beat      (w_beat),
        .i_out_free  (w_out_free)
    );

    // SysEx buffer
    mmf_ram #(
        .DEPTH (SX_CAP),
        .WIDTH (8)
    ) u_sx_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_req.we),
        .i_waddr (w_ram_req.waddr),
        .i_wdata (w_ram_req.wdata),
        .i_re    (w_ram_req.re),
        .i_raddr (w_ram_req.raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register
    mmf_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_trunc (m_axis_tuser[0])
    );

    // No new byte is taken while a message is only partly sent
    `MMF_ASSERT_NOW(a_no_accept_mid_msg, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input accepted in the middle of a message")

    // A truncated run always closes with F7
    `MMF_ASSERT_NOW(a_trunc_ends_eox, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast, m_axis_tdata == SX_END, "truncated SysEx run does not end with F7")

    // Opening a SysEx run produces no output and keeps input open
    `MMF_ASSERT_NEXT(a_sx_start_idle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tdata == SX_START, s_axis_tready, "SysEx start stalled the input")

endmodule

// ----- src/mmf_ram.sv -----
module mmf_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- src/mmf_ctrl.sv -----
module mmf_ctrl
    import mmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output t_ram_req   o_ram_req,
    input  logic [7:0] i_ram_rdata,
    output t_beat      o_beat,
    input  logic       i_out_free
);

    t_state           r_state, n_state;
    logic             r_enabled;
    logic [7:0]       r_running, n_running;
    logic [1:0]       r_expected, n_expected;
    logic [1:0]       r_received, n_received;
    logic [7:0]       r_data1, n_data1;
    logic [7:0]       r_data2, n_data2;
    logic             r_sx_active, n_sx_active;
    logic [CNT_W-1:0] r_sx_count, n_sx_count;
    logic             r_sx_ovf, n_sx_ovf;
    logic [7:0]       r_rt_byte, n_rt_byte;
    logic             r_rt_mode, n_rt_mode;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_trunc, n_trunc;

    logic             w_accept;
    logic             w_go_emit;
    logic             w_go_sx;
    logic             w_last;
    logic [CNT_W-1:0] w_idx_inc;
    logic [1:0]       w_rcv_eff;
    logic [1:0]       w_exp_eff;
    logic [2:0]       w_rcv_inc;
    logic [CNT_W-1:0] w_sx_n;
    logic             w_sx_room;
    logic             w_ram_we;
    logic [SX_AW-1:0] w_ram_waddr;

    assign w_accept  = i_in_valid && (r_state == S_IDLE) && r_enabled;
    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_last    = (w_idx_inc == r_len);
    assign w_rcv_eff = (r_received == 2'd0) ? 2'd1 : r_received;
    assign w_exp_eff = (r_received == 2'd0) ? msg_length(r_running) : r_expected;
    assign w_rcv_inc = {1'b0, w_rcv_eff} + 3'd1;
    assign w_sx_n    = r_sx_count + CNT_W'(1);
    assign w_sx_room = (r_sx_count < SX_CAP_CNT);

    // Parse the accepted byte and advance the emit index
    always_comb begin
        n_running   = r_running;
        n_expected  = r_expected;
        n_received  = r_received;
        n_data1     = r_data1;
        n_data2     = r_data2;
        n_sx_active = r_sx_active;
        n_sx_count  = r_sx_count;
        n_sx_ovf    = r_sx_ovf;
        n_rt_byte   = r_rt_byte;
        n_rt_mode   = r_rt_mode;
        n_len       = r_len;
        n_idx       = r_idx;
        n_trunc     = r_trunc;
        w_go_emit   = 1'b0;
        w_go_sx     = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_sx_count[SX_AW-1:0];

        if (w_accept) begin
            priority if (i_in_byte >= RT_FIRST) begin
                // Real-time byte goes out alone, state untouched
                n_rt_byte = i_in_byte;
                n_rt_mode = 1'b1;
                n_len     = CNT_W'(1);
                n_idx     = '0;
                w_go_emit = 1'b1;
            end else if (i_in_byte == SX_START) begin
                // Open a new SysEx run, dropping any buffered one
                n_sx_active = 1'b1;
                n_sx_ovf    = 1'b0;
                n_sx_count  = CNT_W'(1);
                w_ram_we    = 1'b1;
                w_ram_waddr = '0;
            end else if (r_sx_active) begin
                // Buffer payload; when full, keep only a closing F7
                if (w_sx_room) begin
                    w_ram_we   = 1'b1;
                    n_sx_count = w_sx_n;
                end else begin
                    n_sx_ovf = 1'b1;
                    if (i_in_byte == SX_END) begin
                        w_ram_we    = 1'b1;
                        w_ram_waddr = SX_LAST_ADDR;
                    end
                end
                if (i_in_byte == SX_END) begin
                    n_len       = w_sx_room ? w_sx_n : r_sx_count;
                    n_trunc     = w_sx_room ? r_sx_ovf : 1'b1;
                    n_idx       = '0;
                    n_sx_active = 1'b0;
                    n_sx_count  = '0;
                    n_sx_ovf    = 1'b0;
                    w_go_sx     = 1'b1;
                end
            end else if (i_in_byte[7]) begin
                // Status byte: new running status, one-byte ones emit now
                n_running  = i_in_byte;
                n_expected = msg_length(i_in_byte);
                if (msg_length(i_in_byte) == 2'd1) begin
                    n_received = 2'd0;
                    n_rt_mode  = 1'b0;
                    n_len      = CNT_W'(1);
                    n_idx      = '0;
                    w_go_emit  = 1'b1;
                end else begin
                    n_received = 2'd1;
                end
            end else begin
                // Data byte, with running status when no message is open
                n_expected = w_exp_eff;
                if (w_rcv_eff == 2'd1) begin
                    n_data1 = i_in_byte;
                end else begin
                    n_data2 = i_in_byte;
                end
                if (w_rcv_inc >= {1'b0, w_exp_eff}) begin
                    n_received = 2'd0;
                    if (w_exp_eff != 2'd0) begin
                        n_rt_mode = 1'b0;
                        n_len     = CNT_W'(w_exp_eff);
                        n_idx     = '0;
                        w_go_emit = 1'b1;
                    end
                end else begin
                    n_received = w_rcv_inc[1:0];
                end
            end
        end

        // Advance to the next byte once the output stage takes one
        if ((r_state == S_EMIT || r_state == S_SX_LD) && i_out_free) begin
            n_idx = w_idx_inc;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_go_emit) begin
                    n_state = S_EMIT;
                end else if (w_go_sx) begin
                    n_state = S_SX_RD;
                end
            end
            S_EMIT: begin
                if (i_out_free && w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SX_RD: begin
                n_state = S_SX_LD;
            end
            S_SX_LD: begin
                if (i_out_free) begin
                    n_state = w_last ? S_IDLE : S_SX_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: handshake, RAM request and result beat
    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_ram_req.we    = w_ram_we;
        o_ram_req.waddr = w_ram_waddr;
        o_ram_req.wdata = i_in_byte;
        o_ram_req.re    = (r_state == S_SX_RD);
        o_ram_req.raddr = r_idx[SX_AW-1:0];
        o_beat.valid    = (r_state == S_EMIT) || (r_state == S_SX_LD);
        o_beat.last     = w_last;
        o_beat.trunc    = (r_state == S_SX_LD) && r_trunc;
        if (r_state == S_SX_LD) begin
            o_beat.data = i_ram_rdata;
        end else if (r_rt_mode) begin
            o_beat.data = r_rt_byte;
        end else begin
            unique case (r_idx[1:0])
                2'd0:    o_beat.data = r_running;
                2'd1:    o_beat.data = r_data1;
                default: o_beat.data = r_data2;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b0;
            r_running   <= '0;
            r_expected  <= '0;
            r_received  <= '0;
            r_sx_active <= 1'b0;
            r_sx_count  <= '0;
            r_sx_ovf    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_expected  <= n_expected;
            r_received  <= n_received;
            r_sx_active <= n_sx_active;
            r_sx_count  <= n_sx_count;
            r_sx_ovf    <= n_sx_ovf;
            if (i_cfg_valid) begin
                r_enabled <= i_cfg_data;
            end
        end
    end

    // Payload and emit bookkeeping
    always_ff @(posedge i_clk) begin
        r_data1   <= n_data1;
        r_data2   <= n_data2;
        r_rt_byte <= n_rt_byte;
        r_rt_mode <= n_rt_mode;
        r_len     <= n_len;
        r_idx     <= n_idx;
        r_trunc   <= n_trunc;
    end

endmodule

// ----- src/mmf_out_stage.sv -----
module mmf_out_stage
    import mmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_beat      i_beat,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic       o_trunc
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_trunc;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_trunc = r_trunc;

    // Hold the beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_beat.valid;
        end
    end

    // Load the payload on a new beat
    always_ff @(posedge i_clk) begin
        if (o_free && i_beat.valid) begin
            r_data  <= i_beat.data;
            r_last  <= i_beat.last;
            r_trunc <= i_beat.trunc;
        end
    end

endmodule

// ----- tb/sv/midi_message_framer_unit_test.sv -----
module midi_message_framer_unit_test
    import mmf_pkg::*;
();

    localparam logic [7:0] TUNE_REQUEST = 8'hF6;
    localparam logic [7:0] DATA_MAX     = 8'h7F;
    localparam logic [7:0] RT_LAST      = 8'hFF;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         NUM_STEPS    = 25;

    // One expected output transaction
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       trunc;
    } t_want_beat;

    // Directed row: input byte; known rows give the result by hand
    // (echoes: one message holding the input byte alone, else nothing)
    typedef struct packed {
        logic [7:0] code;
        logic       is_known;
        logic       echoes;
    } t_step;

    localparam t_step DIRECTED_STEPS [NUM_STEPS] = '{
        '{8'h00,        1'b1, 1'b0},  // data before any status
        '{DATA_MAX,     1'b1, 1'b0},
        '{RT_LAST,      1'b1, 1'b1},  // real-time
        '{SX_END,       1'b1, 1'b1},  // end of SysEx with no SysEx open
        '{8'h80,        1'b0, 1'b0},  // note off, three bytes
        '{8'h00,        1'b0, 1'b0},
        '{DATA_MAX,     1'b0, 1'b0},
        '{8'h45,        1'b0, 1'b0},  // running status
        '{8'h00,        1'b0, 1'b0},
        '{ST_PROGRAM,   1'b0, 1'b0},  // two-byte channel message
        '{DATA_MAX,     1'b0, 1'b0},
        '{ST_SONG_POS,  1'b0, 1'b0},  // three-byte system common
        '{8'h01,        1'b0, 1'b0},
        '{8'h02,        1'b0, 1'b0},
        '{TUNE_REQUEST, 1'b1, 1'b1},  // one-byte status
        '{8'h05,        1'b0, 1'b0},  // re-emits the one-byte status
        '{SX_START,     1'b0, 1'b0},
        '{8'h01,        1'b0, 1'b0},
        '{RT_FIRST,     1'b1, 1'b1},  // real-time inside SysEx
        '{8'h90,        1'b0, 1'b0},  // status buffered as SysEx payload
        '{SX_START,     1'b0, 1'b0},  // restart discards the open run
        '{8'h02,        1'b0, 1'b0},
        '{SX_END,       1'b0, 1'b0},
        '{8'hB0,        1'b0, 1'b0},  // left open across a disabled phase
        '{8'h12,        1'b0, 1'b0}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data    = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;

    // Framer shadow state
    logic       out_enabled = 1'b0;
    logic [7:0] run_status  = 8'h00;
    int         msg_need    = 0;
    int         msg_have    = 0;
    logic [7:0] msg_bytes [3];
    logic       sx_open     = 1'b0;
    logic       sx_lost     = 1'b0;
    int         sx_fill     = 0;
    logic [7:0] sx_bytes [SX_CAP];

    t_want_beat awaited_beats [$];
    t_want_beat fresh_beats [$];

    bit calm         = 1'b0;
    int mismatches   = 0;
    int items_framed = 0;
    int beats_seen   = 0;
    int sysex_runs   = 0;
    int sysex_cut    = 0;
    int quiet_cycles = 0;

    midi_message_framer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_want_beat msg_beat(input logic [7:0] v, input logic l, input logic t);
        t_want_beat b;
        b.value = v;
        b.last  = l;
        b.trunc = t;
        return b;
    endfunction

    // Message length implied by a status byte
    function automatic int status_length(input logic [7:0] s);
        int len;
        if (!s[7]) begin
            len = 0;
        end else if (s[7:4] == ST_PROGRAM[7:4] || s[7:4] == ST_PRESSURE[7:4]) begin
            len = 2;
        end else if (s[7:4] != ST_SYSTEM[7:4]) begin
            len = 3;
        end else if (s == SX_START) begin
            len = 0;
        end else if (s == ST_MTC || s == ST_SONG_SEL) begin
            len = 2;
        end else if (s == ST_SONG_POS) begin
            len = 3;
        end else begin
            len = 1;
        end
        return len;
    endfunction

    function automatic void emit_message(input int len);
        for (int i = 0; i < len && i < 3; i++)
            fresh_beats = {fresh_beats, msg_beat(msg_bytes[i], i == len - 1, 1'b0)};
    endfunction

    // Advance the shadow framer by one input byte; results land in fresh_beats
    function automatic void frame_midi_byte(input logic [7:0] code);
        fresh_beats.delete();
        if (out_enabled) begin
            items_framed++;
            if (code >= RT_FIRST) begin
                fresh_beats = {fresh_beats, msg_beat(code, 1'b1, 1'b0)};
            end else if (code == SX_START) begin
                sx_open     = 1'b1;
                sx_lost     = 1'b0;
                sx_bytes[0] = code;
                sx_fill     = 1;
            end else if (sx_open) begin
                if (sx_fill < SX_CAP) begin
                    sx_bytes[sx_fill] = code;
                    sx_fill++;
                end else begin
                    sx_lost = 1'b1;
                    if (code == SX_END)
                        sx_bytes[SX_CAP-1] = code;
                end
                if (code == SX_END) begin
                    for (int i = 0; i < sx_fill; i++)
                        fresh_beats = {fresh_beats,
                                       msg_beat(sx_bytes[i], i == sx_fill - 1, sx_lost)};
                    sysex_runs++;
                    if (sx_lost)
                        sysex_cut++;
                    sx_open = 1'b0;
                    sx_fill = 0;
                    sx_lost = 1'b0;
                end
            end else if (code[7]) begin
                run_status   = code;
                msg_bytes[0] = code;
                msg_have     = 1;
                msg_need     = status_length(code);
                if (msg_need == 1) begin
                    msg_have = 0;
                    emit_message(1);
                end
            end else begin
                // running status: rebuild the header from the last status
                if (msg_have == 0) begin
                    msg_bytes[0] = run_status;
                    msg_have     = 1;
                    msg_need     = status_length(run_status);
                end
                if (msg_have < 3)
                    msg_bytes[msg_have] = code;
                msg_have++;
                if (msg_have >= msg_need) begin
                    emit_message(msg_need);
                    msg_have = 0;
                end
            end
        end
    endfunction

    function automatic bit sender_rests();
        return !calm && ($urandom_range(0, 99) < 33);
    endfunction

    // Offer one byte and hold it until the input transaction completes
    task automatic hand_over(input logic [7:0] code);
        while (sender_rests()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic send_midi_byte(input logic [7:0] code);
        frame_midi_byte(code);
        awaited_beats = {awaited_beats, fresh_beats};
        hand_over(code);
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_output_enable(input logic en);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        out_enabled = en;
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_midi_byte(8'($urandom_range(0, 255)));
    endtask

    // Data bytes with an occasional real-time byte slipped in between
    task automatic send_data_bytes(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 6)
                send_midi_byte(8'($urandom_range(RT_FIRST, RT_LAST)));
            send_midi_byte(8'($urandom_range(0, DATA_MAX)));
        end
    endtask

    task automatic send_random_message();
        int         pick;
        int         count;
        logic [7:0] status;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
            send_midi_byte(status);
            send_data_bytes(status_length(status) - 1);
        end else if (pick < 40) begin
            send_data_bytes($urandom_range(1, 4));
        end else if (pick < 55) begin
            status = 8'($urandom_range(ST_MTC, SX_END));
            send_midi_byte(status);
            send_data_bytes(status_length(status) - 1);
        end else if (pick < 75) begin
            // SysEx, now and then past the buffer depth
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(26, 40)
                                                : $urandom_range(0, 8);
            send_midi_byte(SX_START);
            repeat (count) begin
                if ($urandom_range(0, 9) == 0)
                    send_midi_byte(8'($urandom_range(8'h80, SX_END)));
                else
                    send_data_bytes(1);
            end
            if ($urandom_range(0, 9) != 0)
                send_midi_byte(SX_END);
        end else if (pick < 85) begin
            send_midi_byte(8'($urandom_range(RT_FIRST, RT_LAST)));
        end else begin
            send_noise($urandom_range(1, 3));
        end
    endtask

    task automatic run_random_phase(input int count);
        int start;
        start = items_framed;
        while (items_framed - start < count)
            send_random_message();
    endtask

    // Disable output, feed bytes that must vanish, then enable again
    task automatic run_disabled_gap();
        settle();
        write_output_enable(1'b0);
        send_noise($urandom_range(4, 8));
        settle();
        write_output_enable(1'b1);
    endtask

    // Sink side backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // Compare each output transaction with the oldest expected beat
    always @(posedge i_clk) begin
        t_want_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_beats.size() == 0) begin
                $error("unexpected output: out_byte %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = awaited_beats.pop_front();
                beats_seen++;
                if (m_axis_tdata !== want.value) begin
                    $error("out_byte: expected %h, got %h", want.value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("msg_last: expected %b, got %b", want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.trunc) begin
                    $error("truncated: expected %b, got %b", want.trunc, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("midi_message_framer_unit_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_step step;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // output starts disabled: everything is swallowed
        send_noise(4);
        settle();
        write_output_enable(1'b1);

        for (int i = 0; i < NUM_STEPS; i++) begin
            step = DIRECTED_STEPS[i];
            if (step.is_known) begin
                frame_midi_byte(step.code);
                if (step.echoes)
                    awaited_beats = {awaited_beats, msg_beat(step.code, 1'b1, 1'b0)};
                hand_over(step.code);
            end else begin
                send_midi_byte(step.code);
            end
        end

        // the open control change resumes after the disabled gap
        run_disabled_gap();
        send_midi_byte(8'h34);

        run_random_phase(70);
        run_disabled_gap();
        calm = 1'b1;
        run_random_phase(60);
        calm = 1'b0;
        run_disabled_gap();
        run_random_phase(70);

        settle();
        repeat (12) @(posedge i_clk);
        $display("framed %0d bytes into %0d output transactions", items_framed, beats_seen);
        $display("flushed %0d SysEx runs, %0d of them truncated", sysex_runs, sysex_cut);
        if (mismatches == 0) begin
            $display("midi_message_framer_unit_test: done, clean");
        end else begin
            $display("midi_message_framer_unit_test: done, errors");
        end
        $finish;
    end

endmodule
